### rtl/core/tde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tde_pkg
// shared types, register indexes and reset constants of the tilt estimator
// ----------------------------------------------------------------------------
package tde_pkg;

    localparam int SAMPLE_W = 14;
    localparam int COUNT_W  = 8;
    localparam int PCT_W    = 7;
    localparam int QUAD_W   = 2;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 14;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [CFG_IW-1:0] REG_THRESHOLD_Q0 = 3'd1;
    localparam logic [CFG_IW-1:0] REG_THRESHOLD_Q1 = 3'd2;
    localparam logic [CFG_IW-1:0] REG_THRESHOLD_Q2 = 3'd3;
    localparam logic [CFG_IW-1:0] REG_THRESHOLD_Q3 = 3'd4;

    localparam logic [COUNT_W-1:0]         SAMPLE_COUNT_RST = 8'd100;
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_Q0_RST = 14'sd3052;
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_Q1_RST = 14'sd2952;
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_Q2_RST = -14'sd2834;
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_Q3_RST = -14'sd3052;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // quadrant codes
    localparam logic [QUAD_W-1:0] QUAD_PP = 2'd0;  // x >= 0, y >= 0
    localparam logic [QUAD_W-1:0] QUAD_PN = 2'd1;  // x >= 0, y < 0
    localparam logic [QUAD_W-1:0] QUAD_NN = 2'd2;  // both negative
    localparam logic [QUAD_W-1:0] QUAD_NP = 2'd3;  // x < 0, y >= 0

    typedef enum logic [3:0] {
        S_IDLE,
        S_MX_START,
        S_MX_WAIT,
        S_MY_START,
        S_MY_WAIT,
        S_WALK,
        S_PCT_START,
        S_PCT_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_MEAN_X,
        DIV_MEAN_Y,
        DIV_PCT
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_take;
        logic     walk_init;
        logic     walk_step;
        logic     pct_force;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic last_pair;
        logic div_done;
        logic walk_done;
        logic total_zero;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

### rtl/core/tde_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tde_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tde_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 22
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [DEN_W:0]   shifted;
    logic             fits;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] rem_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = shifted - {1'b0, den_reg};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### rtl/core/tde_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tde_datapath
// sample store, accumulators, config registers, divider, weight walk and output register
// ----------------------------------------------------------------------------
module tde_datapath #(
    parameter int MAX_SAMPLES = 128
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire tde_pkg::cmd_t                          cmd,
    output tde_pkg::sts_t                               sts,
    input  wire logic signed [tde_pkg::SAMPLE_W-1:0]    s_x_sample,
    input  wire logic signed [tde_pkg::SAMPLE_W-1:0]    s_y_sample,
    input  wire logic                                   cfg_valid,
    input  wire logic        [tde_pkg::CFG_IW-1:0]      cfg_index,
    input  wire logic        [tde_pkg::CFG_DW-1:0]      cfg_data,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic             [tde_pkg::QUAD_W-1:0]      m_quadrant,
    output logic                                        m_half,
    output logic             [tde_pkg::PCT_W-1:0]       m_likely_percent,
    output logic             [tde_pkg::PCT_W-1:0]       m_unlikely_percent,
    output logic signed      [tde_pkg::SAMPLE_W-1:0]    m_mean_x,
    output logic signed      [tde_pkg::SAMPLE_W-1:0]    m_mean_y,
    output logic                                        m_no_weight
);
    import tde_pkg::*;

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SUMW  = SAMPLE_W + CW;
    localparam int TOTW  = SAMPLE_W + CW;
    localparam int NUMW  = TOTW + PCT_W;
    localparam int EW    = (CW > COUNT_W) ? CW : COUNT_W;

    // configuration registers
    logic        [COUNT_W-1:0]  sample_count_reg;
    logic signed [SAMPLE_W-1:0] thr_reg [4];

    // gather state
    logic signed [SAMPLE_W-1:0] x_mem [MAX_SAMPLES];
    logic signed [SUMW-1:0]     sum_x_reg;
    logic signed [SUMW-1:0]     sum_y_reg;
    logic        [CW-1:0]       pair_count_reg;

    // estimate state
    logic signed [SAMPLE_W-1:0] mean_x_reg;
    logic signed [SAMPLE_W-1:0] mean_y_reg;
    logic        [CW-1:0]       rd_addr_reg;
    logic                       rd_valid_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic        [TOTW-1:0]     likely_reg;
    logic        [TOTW-1:0]     total_reg;
    logic        [PCT_W-1:0]    pct_reg;
    logic                       no_weight_reg;

    // output register
    logic                       m_valid_reg;
    logic        [QUAD_W-1:0]   m_quadrant_reg;
    logic                       m_half_reg;
    logic        [PCT_W-1:0]    m_likely_reg;
    logic        [PCT_W-1:0]    m_unlikely_reg;
    logic signed [SAMPLE_W-1:0] m_mean_x_reg;
    logic signed [SAMPLE_W-1:0] m_mean_y_reg;
    logic                       m_no_weight_reg;

    // effective count: zero counts as one, saturate at store depth
    logic [EW-1:0] sc_ext;
    logic [CW-1:0] eff_count;
    logic [CW-1:0] pair_count_next;

    always_comb begin
        sc_ext = EW'(sample_count_reg);
        if (sc_ext == '0) begin
            eff_count = CW'(1);
        end else if (sc_ext > EW'(MAX_SAMPLES)) begin
            eff_count = CW'(MAX_SAMPLES);
        end else begin
            eff_count = sc_ext[CW-1:0];
        end
        pair_count_next = pair_count_reg + 1'b1;
    end

    // divider operand selection
    logic [SUMW-1:0] sum_x_mag;
    logic [SUMW-1:0] sum_y_mag;
    logic [NUMW-1:0] div_dividend;
    logic [TOTW-1:0] div_divisor;
    logic            div_done;
    logic [NUMW-1:0] div_quotient;

    always_comb begin
        sum_x_mag = sum_x_reg[SUMW-1] ? SUMW'(-sum_x_reg) : SUMW'(sum_x_reg);
        sum_y_mag = sum_y_reg[SUMW-1] ? SUMW'(-sum_y_reg) : SUMW'(sum_y_reg);
        case (cmd.div_sel)
            DIV_MEAN_X: begin
                div_dividend = NUMW'(sum_x_mag);
                div_divisor  = TOTW'(pair_count_reg);
            end
            DIV_MEAN_Y: begin
                div_dividend = NUMW'(sum_y_mag);
                div_divisor  = TOTW'(pair_count_reg);
            end
            default: begin
                div_dividend = NUMW'(likely_reg) * NUMW'(PCT_FULL);
                div_divisor  = total_reg;
            end
        endcase
    end

    tde_div #(
        .NUM_W (NUMW),
        .DEN_W (TOTW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    logic [SAMPLE_W-1:0] quo_mean;
    assign quo_mean = div_quotient[SAMPLE_W-1:0];

    // quadrant and threshold from the latched means
    logic        [QUAD_W-1:0]   quad;
    logic signed [SAMPLE_W-1:0] thr;
    logic signed [SAMPLE_W:0]   mean_diff;
    logic                       mean_above;

    always_comb begin
        quad       = {mean_x_reg[SAMPLE_W-1], mean_x_reg[SAMPLE_W-1] ^ mean_y_reg[SAMPLE_W-1]};
        thr        = thr_reg[quad];
        mean_diff  = (SAMPLE_W+1)'(mean_x_reg) - (SAMPLE_W+1)'(thr);
        mean_above = !mean_diff[SAMPLE_W];
    end

    // per-sample distance from threshold
    logic signed [SAMPLE_W:0]   smp_diff;
    logic signed [SAMPLE_W:0]   smp_abs;
    logic                       smp_above;
    logic        [SAMPLE_W-1:0] smp_dist;

    always_comb begin
        smp_diff  = (SAMPLE_W+1)'(rd_data_reg) - (SAMPLE_W+1)'(thr);
        smp_above = !smp_diff[SAMPLE_W];
        smp_abs   = smp_above ? smp_diff : -smp_diff;
        smp_dist  = smp_abs[SAMPLE_W-1:0];
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            thr_reg[0]       <= THRESHOLD_Q0_RST;
            thr_reg[1]       <= THRESHOLD_Q1_RST;
            thr_reg[2]       <= THRESHOLD_Q2_RST;
            thr_reg[3]       <= THRESHOLD_Q3_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[COUNT_W-1:0];
                REG_THRESHOLD_Q0: thr_reg[0] <= cfg_data;
                REG_THRESHOLD_Q1: thr_reg[1] <= cfg_data;
                REG_THRESHOLD_Q2: thr_reg[2] <= cfg_data;
                REG_THRESHOLD_Q3: thr_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // sample store: one write port while gathering, one read port for the walk
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            x_mem[pair_count_reg[AW-1:0]] <= s_x_sample;
        end
        if (cmd.walk_step) begin
            rd_data_reg <= x_mem[rd_addr_reg[AW-1:0]];
        end
    end

    // accumulators, cleared once the result goes to the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            pair_count_reg <= '0;
        end else if (cmd.accept) begin
            sum_x_reg      <= sum_x_reg + SUMW'(s_x_sample);
            sum_y_reg      <= sum_y_reg + SUMW'(s_y_sample);
            pair_count_reg <= pair_count_next;
        end else if (cmd.load_out) begin
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            pair_count_reg <= '0;
        end
    end

    // means and percentage from the divider
    always_ff @(posedge aclk) begin
        if (cmd.div_take) begin
            case (cmd.div_sel)
                DIV_MEAN_X: mean_x_reg <= sum_x_reg[SUMW-1] ? -quo_mean : quo_mean;
                DIV_MEAN_Y: mean_y_reg <= sum_y_reg[SUMW-1] ? -quo_mean : quo_mean;
                default: begin
                    pct_reg       <= div_quotient[PCT_W-1:0];
                    no_weight_reg <= 1'b0;
                end
            endcase
        end else if (cmd.pct_force) begin
            pct_reg       <= PCT_FULL;
            no_weight_reg <= 1'b1;
        end
    end

    // weight walk: registered read of the sample store, accumulate the registered sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end else if (cmd.walk_init) begin
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end else if (cmd.walk_step) begin
            rd_valid_reg <= rd_addr_reg != pair_count_reg;
            if (rd_addr_reg != pair_count_reg) begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_init) begin
            likely_reg <= '0;
            total_reg  <= '0;
        end else if (cmd.walk_step && rd_valid_reg) begin
            total_reg <= total_reg + TOTW'(smp_dist);
            if (smp_above == mean_above) begin
                likely_reg <= likely_reg + TOTW'(smp_dist);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_quadrant_reg  <= quad;
            m_half_reg      <= (quad == QUAD_PP || quad == QUAD_NP) ? mean_above : !mean_above;
            m_likely_reg    <= pct_reg;
            m_unlikely_reg  <= PCT_FULL - pct_reg;
            m_mean_x_reg    <= mean_x_reg;
            m_mean_y_reg    <= mean_y_reg;
            m_no_weight_reg <= no_weight_reg;
        end
    end

    always_comb begin
        sts.last_pair  = pair_count_next >= eff_count;
        sts.div_done   = div_done;
        sts.walk_done  = (rd_addr_reg == pair_count_reg) && !rd_valid_reg;
        sts.total_zero = total_reg == '0;
        sts.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid            = m_valid_reg;
    assign m_quadrant         = m_quadrant_reg;
    assign m_half             = m_half_reg;
    assign m_likely_percent   = m_likely_reg;
    assign m_unlikely_percent = m_unlikely_reg;
    assign m_mean_x           = m_mean_x_reg;
    assign m_mean_y           = m_mean_y_reg;
    assign m_no_weight        = m_no_weight_reg;

endmodule
`default_nettype wire

### rtl/core/tde_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tde_ctrl
// sequencer: gather pairs, two mean divisions, weight walk, percent division
// ----------------------------------------------------------------------------
module tde_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output tde_pkg::cmd_t      cmd,
    input  wire tde_pkg::sts_t sts
);
    import tde_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_MEAN_X;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && sts.last_pair) begin
                    state_next = S_MX_START;
                end
            end
            S_MX_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_MX_WAIT;
            end
            S_MX_WAIT: begin
                if (sts.div_done) begin
                    cmd.div_take = 1'b1;
                    state_next   = S_MY_START;
                end
            end
            S_MY_START: begin
                cmd.div_sel   = DIV_MEAN_Y;
                cmd.div_start = 1'b1;
                state_next    = S_MY_WAIT;
            end
            S_MY_WAIT: begin
                cmd.div_sel = DIV_MEAN_Y;
                if (sts.div_done) begin
                    cmd.div_take  = 1'b1;
                    cmd.walk_init = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done) begin
                    state_next = S_PCT_START;
                end
            end
            S_PCT_START: begin
                cmd.div_sel = DIV_PCT;
                if (sts.total_zero) begin
                    cmd.pct_force = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_PCT_WAIT;
                end
            end
            S_PCT_WAIT: begin
                cmd.div_sel = DIV_PCT;
                if (sts.div_done) begin
                    cmd.div_take = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/tilt_direction_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_direction_estimator
// averages accelerometer x/y pairs and estimates the tilt quadrant and half
// ----------------------------------------------------------------------------
// Each accepted x/y pair is summed and its x kept. The pair that completes an
// estimate starts the finishing sequence, during which no pair is taken: two
// mean divisions and one percent division on a shared restoring divider
// that yields one quotient bit per cycle over D = 21 + clog2(MAX_SAMPLES + 1)
// bits, and a walk over the N stored x values through the single read port
// of the sample store. The percent division is skipped when the total
// weight is zero, and the sequence waits at its end only while an earlier
// result still waits in the output register. The result sits in that output
// register, so a new estimate can start gathering while it waits to be
// taken. Thresholds and the sample count are written over the cfg port,
// which is always ready.
// ----------------------------------------------------------------------------
module tilt_direction_estimator #(
    parameter int MAX_SAMPLES = 128
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [tde_pkg::SAMPLE_W-1:0] s_x_sample,
    input  wire logic signed [tde_pkg::SAMPLE_W-1:0] s_y_sample,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic             [tde_pkg::QUAD_W-1:0]   m_quadrant,
    output logic                                     m_half,
    output logic             [tde_pkg::PCT_W-1:0]    m_likely_percent,
    output logic             [tde_pkg::PCT_W-1:0]    m_unlikely_percent,
    output logic signed      [tde_pkg::SAMPLE_W-1:0] m_mean_x,
    output logic signed      [tde_pkg::SAMPLE_W-1:0] m_mean_y,
    output logic                                     m_no_weight,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic        [tde_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic        [tde_pkg::CFG_DW-1:0]   cfg_data
);
    import tde_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    tde_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_x_sample         (s_x_sample),
        .s_y_sample         (s_y_sample),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_quadrant         (m_quadrant),
        .m_half             (m_half),
        .m_likely_percent   (m_likely_percent),
        .m_unlikely_percent (m_unlikely_percent),
        .m_mean_x           (m_mean_x),
        .m_mean_y           (m_mean_y),
        .m_no_weight        (m_no_weight)
    );

endmodule
`default_nettype wire

### rtl/core/tde_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tde_checker
// port-level checks on the result channel of the tilt estimator
// ----------------------------------------------------------------------------
module tde_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic             [tde_pkg::QUAD_W-1:0]   m_quadrant,
    input wire logic             [tde_pkg::PCT_W-1:0]    m_likely_percent,
    input wire logic             [tde_pkg::PCT_W-1:0]    m_unlikely_percent,
    input wire logic signed      [tde_pkg::SAMPLE_W-1:0] m_mean_x,
    input wire logic signed      [tde_pkg::SAMPLE_W-1:0] m_mean_y,
    input wire logic                                m_no_weight
);
    import tde_pkg::*;

    // a stalled transfer stays valid and keeps its likely percent, means and quadrant
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_likely_percent)
            && $stable(m_mean_x) && $stable(m_mean_y) && $stable(m_quadrant))
        else $error("result changed while stalled");

    a_pct_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_likely_percent + m_unlikely_percent) == PCT_FULL)
        else $error("percentages do not add to one hundred");

    a_no_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_weight |-> m_likely_percent == PCT_FULL)
        else $error("zero weight without full percentage");

    // quadrant follows the mean signs
    a_quadrant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_quadrant == {m_mean_x[SAMPLE_W-1],
                                   m_mean_x[SAMPLE_W-1] ^ m_mean_y[SAMPLE_W-1]})
        else $error("quadrant does not match mean signs");

endmodule

bind tilt_direction_estimator tde_checker u_tde_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_quadrant         (m_quadrant),
    .m_likely_percent   (m_likely_percent),
    .m_unlikely_percent (m_unlikely_percent),
    .m_mean_x           (m_mean_x),
    .m_mean_y           (m_mean_y),
    .m_no_weight        (m_no_weight)
);
`default_nettype wire
